// ----- rtl/crbg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crbg_pkg
// Shared types, constants and helper functions for the connect retry
// backoff guard.
// ----------------------------------------------------------------------------
package crbg_pkg;

	localparam int ENTRIES    = 64;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int EP_W       = 6;
	localparam int TIME_W     = 48;
	localparam int CNT_W      = 32;
	localparam int TRACK_W    = 7;
	localparam int GAP_W      = 16;
	localparam int RUN_W      = 4;
	localparam int WAIT_W     = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] OP_ATTEMPT = 2'd0;
	localparam logic [1:0] OP_FAIL    = 2'd1;
	localparam logic [1:0] OP_SUCCESS = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HALTED  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'b1;

	localparam logic [GAP_W-1:0]   MIN_GAP_RESET = 16'd900;
	localparam logic [CNT_W-1:0]   CNT_MAX       = {CNT_W{1'b1}};
	localparam logic [TRACK_W-1:0] TRACK_MAX     = {TRACK_W{1'b1}};
	localparam logic [TIME_W-1:0]  TIME_MAX      = {TIME_W{1'b1}};

	// failure schedules
	localparam logic [RUN_W-1:0]  MAN_RUN_CAP  = 4'd8;
	localparam logic [RUN_W-1:0]  AUTO_RUN_CAP = 4'd10;
	localparam logic [WAIT_W-1:0] MAN_BASE     = 14'd2500;
	localparam logic [WAIT_W-1:0] MAN_TOP      = 14'd12000;
	localparam logic [WAIT_W-1:0] AUTO_BASE    = 14'd2000;
	localparam logic [WAIT_W-1:0] AUTO_TOP     = 14'd15000;

	typedef enum logic [2:0] {
		VERDICT_GRANTED     = 3'd0,
		VERDICT_HALTED      = 3'd1,
		VERDICT_SKIP        = 3'd2,
		VERDICT_DEDUP       = 3'd3,
		VERDICT_NOT_ATTEMPT = 3'd4
	} verdict_t;

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} state_t;

	typedef struct packed {
		logic [RUN_W-1:0]  fail_run;
		logic              armed;
		logic              attempted;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] last_time;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic     write;
		logic     touch_new;
		logic     grant;
		logic     dedup;
		logic     skip;
		logic     fail;
		verdict_t verdict;
	} upd_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	// backoff for a failure run already raised and capped (run >= 1)
	function automatic logic [WAIT_W-1:0] retry_wait(input logic manual,
			input logic [RUN_W-1:0] run);
		logic [RUN_W-1:0] sh;
		logic [WAIT_W-1:0] w;
		sh = run - 1'b1;
		if (manual) begin
			case (sh)
				4'd0:    w = MAN_BASE;
				4'd1:    w = MAN_BASE << 1;
				4'd2:    w = MAN_BASE << 2;
				default: w = MAN_TOP;
			endcase
		end else begin
			case (sh)
				4'd0:    w = AUTO_BASE;
				4'd1:    w = AUTO_BASE << 1;
				4'd2:    w = AUTO_BASE << 2;
				default: w = AUTO_TOP;
			endcase
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/crbg_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crbg_req_if
// Event channel: attempt requests and failure / success reports.
// ----------------------------------------------------------------------------
interface crbg_req_if;
	import crbg_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [EP_W-1:0]   endpoint_index;
	logic              manual;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output op, output endpoint_index, output manual,
		output now_ms, input ready);
	modport sink (input valid, input op, input endpoint_index, input manual,
		input now_ms, output ready);
endinterface
`default_nettype wire

// ----- rtl/crbg_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crbg_rsp_if
// Result channel: verdict and global counters, one per event.
// ----------------------------------------------------------------------------
interface crbg_rsp_if;
	import crbg_pkg::*;

	logic               valid;
	logic               ready;
	logic               allowed;
	logic [2:0]         verdict;
	logic [CNT_W-1:0]   attempt_count;
	logic [CNT_W-1:0]   dedup_count;
	logic [CNT_W-1:0]   failure_count;
	logic [CNT_W-1:0]   skip_count;
	logic [TRACK_W-1:0] tracked_count;

	modport source (output valid, output allowed, output verdict, output attempt_count,
		output dedup_count, output failure_count, output skip_count,
		output tracked_count, input ready);
	modport sink (input valid, input allowed, input verdict, input attempt_count,
		input dedup_count, input failure_count, input skip_count,
		input tracked_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/connect_retry_backoff_guard.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// connect_retry_backoff_guard
// Per-endpoint exponential backoff limiter for connection attempts.
// ----------------------------------------------------------------------------
// For each event on req, the accepting edge reads the endpoint's entry from
// the entry RAM, and the update edge writes the updated entry back and
// loads the result register, after which req is ready again. So a new event
// is not taken before the last one is through; a held rsp holds the update
// step until the result register frees. Per-entry flags start cleared
// through a row of valid bits cleared by reset, so no clearing pass is
// needed and events are taken straight after reset.
// Configuration writes are registered.
module connect_retry_backoff_guard (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	crbg_req_if.sink                             req,
	crbg_rsp_if.source                           rsp,
	input  wire logic                            cfg_we,
	input  wire logic [crbg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [crbg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import crbg_pkg::*;

	state_t state_q, state_d;

	logic                halted_q;
	logic [GAP_W-1:0]    min_gap_q;

	logic [1:0]          op_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                manual_s1;
	logic [TIME_W-1:0]   now_s1;

	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRY_W-1:0]  ram_rdata;
	logic                req_xfer;
	logic                fire;
	logic                out_free;
	logic                present;
	entry_t              cur;
	entry_t              nxt;
	upd_t                ctl;

	logic [CNT_W-1:0]    granted_q, dedup_q, failure_q, skip_q;
	logic [CNT_W-1:0]    granted_d, dedup_d, failure_d, skip_d;
	logic [TRACK_W-1:0]  tracked_q, tracked_d;

	logic                rsp_valid_q;
	logic                allowed_q;
	verdict_t            verdict_q;
	logic [CNT_W-1:0]    att_out_q, dedup_out_q, fail_out_q, skip_out_q;
	logic [TRACK_W-1:0]  tracked_out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q  <= 1'b0;
			min_gap_q <= MIN_GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALTED:  halted_q  <= cfg_wdata[0];
				CFG_MIN_GAP: min_gap_q <= cfg_wdata[GAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !rsp_valid_q || rsp.ready;
	assign req_xfer = req.valid && req.ready;

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		fire      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (out_free) begin
					fire    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_s1     <= req.op;
			idx_s1    <= req.endpoint_index[IDX_W-1:0];
			manual_s1 <= req.manual;
			now_s1    <= req.now_ms;
		end
	end

	// write-back happens before the next read can be issued, so no forwarding
	crbg_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (fire && ctl.write),
		.waddr (idx_s1),
		.wdata (nxt),
		.re    (req_xfer),
		.raddr (req.endpoint_index[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// an entry never written reads as cleared flags
	assign present = valid_q[idx_s1];
	assign cur     = present ? entry_t'(ram_rdata) : '0;

	crbg_update u_update (
		.op         (op_s1),
		.manual     (manual_s1),
		.now_ms     (now_s1),
		.halted     (halted_q),
		.min_gap_ms (min_gap_q),
		.present    (present),
		.cur        (cur),
		.nxt        (nxt),
		.ctl        (ctl)
	);

	always_comb begin
		granted_d = ctl.grant ? sat_inc(granted_q) : granted_q;
		dedup_d   = ctl.dedup ? sat_inc(dedup_q) : dedup_q;
		failure_d = ctl.fail ? sat_inc(failure_q) : failure_q;
		skip_d    = ctl.skip ? sat_inc(skip_q) : skip_q;
		tracked_d = (ctl.touch_new && tracked_q != TRACK_MAX) ? tracked_q + 1'b1 : tracked_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			granted_q   <= '0;
			dedup_q     <= '0;
			failure_q   <= '0;
			skip_q      <= '0;
			tracked_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (ctl.write) begin
					valid_q[idx_s1] <= 1'b1;
				end
				granted_q   <= granted_d;
				dedup_q     <= dedup_d;
				failure_q   <= failure_d;
				skip_q      <= skip_d;
				tracked_q   <= tracked_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			allowed_q     <= ctl.grant;
			verdict_q     <= ctl.verdict;
			att_out_q     <= granted_d;
			dedup_out_q   <= dedup_d;
			fail_out_q    <= failure_d;
			skip_out_q    <= skip_d;
			tracked_out_q <= tracked_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.allowed       = allowed_q;
	assign rsp.verdict       = verdict_q;
	assign rsp.attempt_count = att_out_q;
	assign rsp.dedup_count   = dedup_out_q;
	assign rsp.failure_count = fail_out_q;
	assign rsp.skip_count    = skip_out_q;
	assign rsp.tracked_count = tracked_out_q;

`ifndef ASSERT_OFF
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> state_q == ST_CALC)
		else $error("transfer on req not followed by entry update cycle");

	a_granted_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> granted_q >= $past(granted_q))
		else $error("granted counter went backwards");

	a_tracked_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tracked_q <= TRACK_W'(ENTRIES))
		else $error("more entries tracked than the table holds");

	a_allowed_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (allowed_q == (verdict_q == VERDICT_GRANTED)))
		else $error("allowed disagrees with verdict");
`endif
endmodule
`default_nettype wire

// ----- rtl/crbg_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crbg_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module crbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/crbg_update.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crbg_update
// Per-event decision and entry update: admission checks for attempts,
// backoff scheduling for failures, clearing for successes.
// ----------------------------------------------------------------------------
module crbg_update (
	input  wire logic [1:0]                  op,
	input  wire logic                        manual,
	input  wire logic [crbg_pkg::TIME_W-1:0] now_ms,
	input  wire logic                        halted,
	input  wire logic [crbg_pkg::GAP_W-1:0]  min_gap_ms,
	input  wire logic                        present,
	input  wire crbg_pkg::entry_t            cur,
	output crbg_pkg::entry_t                 nxt,
	output crbg_pkg::upd_t                   ctl
);
	import crbg_pkg::*;

	logic [TIME_W-1:0] since_last;
	logic              gap_short;
	logic              in_backoff;
	logic [RUN_W-1:0]  run_cap;
	logic [RUN_W-1:0]  run_next;
	logic [WAIT_W-1:0] wait_ms;
	logic [TIME_W:0]   dl_sum;

	always_comb begin
		since_last = now_ms - cur.last_time;
		// time going backwards counts as a zero gap
		gap_short  = (now_ms < cur.last_time) ||
			(since_last < {{(TIME_W-GAP_W){1'b0}}, min_gap_ms});
		in_backoff = cur.armed && (now_ms < cur.deadline);

		run_cap  = manual ? MAN_RUN_CAP : AUTO_RUN_CAP;
		run_next = (cur.fail_run >= run_cap) ? run_cap : cur.fail_run + 1'b1;
		wait_ms  = retry_wait(manual, run_next);
		dl_sum   = {1'b0, now_ms} + {{(TIME_W+1-WAIT_W){1'b0}}, wait_ms};

		nxt         = cur;
		ctl         = '0;
		ctl.verdict = VERDICT_NOT_ATTEMPT;

		case (op)
			OP_ATTEMPT: begin
				if (halted) begin
					ctl.verdict = VERDICT_HALTED;
				end else begin
					ctl.write     = 1'b1;
					ctl.touch_new = !present;
					if (in_backoff) begin
						ctl.skip    = 1'b1;
						ctl.verdict = VERDICT_SKIP;
					end else if (!manual && cur.attempted && gap_short) begin
						ctl.dedup   = 1'b1;
						ctl.verdict = VERDICT_DEDUP;
					end else begin
						ctl.grant     = 1'b1;
						ctl.verdict   = VERDICT_GRANTED;
						nxt.last_time = now_ms;
						nxt.attempted = 1'b1;
					end
				end
			end
			OP_FAIL: begin
				ctl.write     = 1'b1;
				ctl.touch_new = !present;
				ctl.fail      = 1'b1;
				nxt.fail_run  = run_next;
				nxt.armed     = 1'b1;
				nxt.deadline  = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
			end
			OP_SUCCESS: begin
				if (present) begin
					ctl.write    = 1'b1;
					nxt.fail_run = '0;
					nxt.armed    = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire
